// ----- design/uvp_pkg.sv -----
package uvp_pkg;

	localparam logic [5:0] POS_SAT       = 6'd41;
	localparam logic [5:0] STRICT_LEN    = 6'd36;
	localparam logic [5:0] LEGACY_LEN    = 6'd40;
	localparam logic [2:0] DASH_SAT      = 3'd5;
	localparam logic [2:0] LEGACY_DASHES = 3'd4;
	localparam logic [7:0] DASH_CHAR     = 8'h2D;

	// one character beat handed to the parse state
	typedef struct packed {
		logic       take;
		logic       eos;
		logic [7:0] character;
	} step_t;

	typedef struct packed {
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
		logic        strict_valid;
		logic        already_lower;
		logic        legacy_valid;
		logic        accepted;
		logic        needs_normalizing;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic       upper;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok    = 1'b1;
			h.upper = 1'b1;
			h.val   = c[3:0] + 4'd9;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

	function automatic logic is_dash_slot(input logic [5:0] p);
		return (p == 6'd8) || (p == 6'd13) || (p == 6'd18) || (p == 6'd23);
	endfunction

	// second digit of a byte: digit index (position minus dashes before it) is odd
	function automatic logic digit_odd(input logic [5:0] p);
		logic [5:0] d;
		d = p - {5'b0, p > 6'd8} - {5'b0, p > 6'd13}
		      - {5'b0, p > 6'd18} - {5'b0, p > 6'd23};
		return d[0];
	endfunction

endpackage

// ----- design/uvp_parse.sv -----
module uvp_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  uvp_pkg::step_t  step,
	output uvp_pkg::result_t result
);
	import uvp_pkg::*;

	logic [5:0]   pos_q, pos_d;
	logic [127:0] acc_q, acc_d;
	logic [3:0]   nib_q, nib_d;
	logic         strict_fail_q, strict_fail_d;
	logic         upper_q, upper_d;
	logic [2:0]   dash_q, dash_d;
	logic         bad_q, bad_d;

	hex_t hx;
	logic is_dash;
	logic strict, lower, legacy, acc_ok;

	always_comb begin
		strict = !strict_fail_q && (pos_q == STRICT_LEN);
		lower  = strict && !upper_q;
		legacy = !bad_q && (((pos_q == STRICT_LEN) && (dash_q == LEGACY_DASHES)) ||
		                    ((pos_q == LEGACY_LEN) && (dash_q == 3'd0)));
		acc_ok = strict || legacy;
		result.uuid_high         = strict ? acc_q[127:64] : 64'd0;
		result.uuid_low          = strict ? acc_q[63:0] : 64'd0;
		result.strict_valid      = strict;
		result.already_lower     = lower;
		result.legacy_valid      = legacy;
		result.accepted          = acc_ok;
		result.needs_normalizing = acc_ok && !lower;
	end

	always_comb begin
		hx            = hex_decode(step.character);
		is_dash       = (step.character == DASH_CHAR);
		pos_d         = pos_q;
		acc_d         = acc_q;
		nib_d         = nib_q;
		strict_fail_d = strict_fail_q;
		upper_d       = upper_q;
		dash_d        = dash_q;
		bad_d         = bad_q;
		if (step.take) begin
			if (step.eos) begin
				pos_d         = '0;
				acc_d         = '0;
				nib_d         = '0;
				strict_fail_d = 1'b0;
				upper_d       = 1'b0;
				dash_d        = '0;
				bad_d         = 1'b0;
			end else if (pos_q < POS_SAT) begin
				if (is_dash) begin
					if (dash_q < DASH_SAT)
						dash_d = dash_q + 3'd1;
				end else if (!hx.ok) begin
					bad_d = 1'b1;
				end
				if (!strict_fail_q) begin
					if (pos_q >= STRICT_LEN) begin
						strict_fail_d = 1'b1;
					end else if (is_dash_slot(pos_q)) begin
						if (!is_dash)
							strict_fail_d = 1'b1;
					end else if (!hx.ok) begin
						strict_fail_d = 1'b1;
					end else begin
						if (hx.upper)
							upper_d = 1'b1;
						if (!digit_odd(pos_q))
							nib_d = hx.val;
						else
							acc_d = {acc_q[119:0], nib_q, hx.val};
					end
				end
				pos_d = pos_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			acc_q         <= '0;
			nib_q         <= '0;
			strict_fail_q <= 1'b0;
			upper_q       <= 1'b0;
			dash_q        <= '0;
			bad_q         <= 1'b0;
		end else begin
			pos_q         <= pos_d;
			acc_q         <= acc_d;
			nib_q         <= nib_d;
			strict_fail_q <= strict_fail_d;
			upper_q       <= upper_d;
			dash_q        <= dash_d;
			bad_q         <= bad_d;
		end
	end

endmodule

// ----- design/uuid_text_validate_parse_core.sv -----
// UUID text checker and parser.
// Source channel (src_valid/src_stall): one beat per text character, then one
// beat with end_of_string set; character is ignored on that beat.
// Result channel (res_valid/res_stall): one beat per end beat, carrying the
// parsed 128-bit value and the strict/legacy/lower-case verdicts.
// Throughput: one source beat per cycle while src_stall is low. Each beat is
// captured in an input register and then folded into the parse state; an end
// beat's result is written to the result register when the beat is folded in.
// While the receiver stalls a result, character beats keep flowing; only an
// end beat waits in the input register, holding src_stall high, until the
// result register frees up.
// Reset clears the parse state and both valid flags; the next beat starts a
// new string. After each end beat the state returns to its reset values.
module uuid_text_validate_parse_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  character,
	input  logic        end_of_string,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] uuid_high,
	output logic [63:0] uuid_low,
	output logic        strict_valid,
	output logic        already_lower,
	output logic        legacy_valid,
	output logic        accepted,
	output logic        needs_normalizing
);
	import uvp_pkg::*;

	logic       valid_s1;
	logic       eos_s1;
	logic [7:0] char_s1;
	logic       take_s1;
	logic       res_free;
	logic       res_valid_q;
	step_t      step;
	result_t    res_d, res_q;

	assign res_free  = !res_valid_q || !res_stall;
	assign take_s1   = valid_s1 && (!eos_s1 || res_free);
	assign src_stall = valid_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			eos_s1  <= end_of_string;
			char_s1 <= character;
		end
	end

	assign step.take      = take_s1;
	assign step.eos       = eos_s1;
	assign step.character = char_s1;

	uvp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_s1 && eos_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && eos_s1)
			res_q <= res_d;
	end

	assign res_valid         = res_valid_q;
	assign uuid_high         = res_q.uuid_high;
	assign uuid_low          = res_q.uuid_low;
	assign strict_valid      = res_q.strict_valid;
	assign already_lower     = res_q.already_lower;
	assign legacy_valid      = res_q.legacy_valid;
	assign accepted          = res_q.accepted;
	assign needs_normalizing = res_q.needs_normalizing;

endmodule

// ----- design/uvp_checker.sv -----
module uvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [63:0] uuid_high,
	input logic [63:0] uuid_low,
	input logic        strict_valid,
	input logic        already_lower,
	input logic        legacy_valid,
	input logic        accepted,
	input logic        needs_normalizing
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(uuid_high) && $stable(uuid_low)
			&& $stable(accepted))
		else $error("result beat changed while stalled");

	// canonical form always passes the legacy check too
	a_strict_legacy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && strict_valid |-> legacy_valid && accepted)
		else $error("strict result without legacy/accepted");

	a_not_strict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !strict_valid |-> uuid_high == 64'd0 && uuid_low == 64'd0
			&& !already_lower)
		else $error("non-strict result carries a value");

	a_verdicts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (accepted == (strict_valid || legacy_valid))
			&& (needs_normalizing == (accepted && !already_lower)))
		else $error("inconsistent verdict bits");

endmodule

bind uuid_text_validate_parse_core uvp_checker u_uvp_checker (.*);
